// File: rtl/core/hsvg_pkg.sv
`default_nettype none

package hsvg_pkg;

    // Configuration register map
    localparam int unsigned APB_AW = 3;
    localparam logic REG_GAMMA_ENABLE = 1'b0;

    // Hue scaling onto six ramps of 255 steps
    localparam logic [26:0] HUE_SCALE = 27'd1530;
    localparam logic [26:0] HUE_ROUND = 27'd32768;
    localparam logic [10:0] HUE_MAX   = 11'd1529;
    localparam logic [10:0] HUE_WRAP  = 11'd1530;
    localparam logic [10:0] SEG_1     = 11'd255;
    localparam logic [10:0] SEG_2     = 11'd510;
    localparam logic [10:0] SEG_3     = 11'd765;
    localparam logic [10:0] SEG_4     = 11'd1020;
    localparam logic [10:0] SEG_5     = 11'd1275;

    // Full-saturation base color with the mixing operands
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] sat;
        logic [7:0] val;
    } hsvg_base_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } hsvg_rgb_t;

    // Gamma 2.6 curve
    localparam logic [7:0] GAMMA_ROM [256] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd3,   8'd3,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,
        8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,
        8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,
        8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,
        8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,
        8'd16,  8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,
        8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,
        8'd25,  8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,
        8'd30,  8'd31,  8'd31,  8'd32,  8'd33,  8'd34,  8'd34,  8'd35,
        8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,
        8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,
        8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,
        8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,
        8'd66,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,  8'd73,  8'd75,
        8'd76,  8'd77,  8'd78,  8'd80,  8'd81,  8'd82,  8'd84,  8'd85,
        8'd86,  8'd88,  8'd89,  8'd90,  8'd92,  8'd93,  8'd94,  8'd96,
        8'd97,  8'd99,  8'd100, 8'd102, 8'd103, 8'd105, 8'd106, 8'd108,
        8'd109, 8'd111, 8'd112, 8'd114, 8'd115, 8'd117, 8'd119, 8'd120,
        8'd122, 8'd124, 8'd125, 8'd127, 8'd129, 8'd130, 8'd132, 8'd134,
        8'd136, 8'd137, 8'd139, 8'd141, 8'd143, 8'd145, 8'd146, 8'd148,
        8'd150, 8'd152, 8'd154, 8'd156, 8'd158, 8'd160, 8'd162, 8'd164,
        8'd166, 8'd168, 8'd170, 8'd172, 8'd174, 8'd176, 8'd178, 8'd180,
        8'd182, 8'd184, 8'd186, 8'd188, 8'd191, 8'd193, 8'd195, 8'd197,
        8'd199, 8'd202, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd215,
        8'd218, 8'd220, 8'd223, 8'd225, 8'd227, 8'd230, 8'd232, 8'd235,
        8'd237, 8'd240, 8'd242, 8'd245, 8'd247, 8'd250, 8'd252, 8'd255
    };

endpackage

`default_nettype wire

// File: rtl/core/hsvg_hue.sv
`default_nettype none

// Two stages: scale the hue onto 0..1529, then build the base color.
module hsvg_hue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [15:0]        hue,
    input  wire logic [7:0]         saturation,
    input  wire logic [7:0]         value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hsvg_pkg::hsvg_base_t    out_data
);
    import hsvg_pkg::*;

    logic        s1_valid_reg;
    logic        s1_ready;
    logic [10:0] s1_hue_reg;
    logic [7:0]  s1_sat_reg;
    logic [7:0]  s1_val_reg;
    logic [26:0] scaled;
    logic [10:0] hue_next;

    logic        s2_valid_reg;
    logic        s2_ready;
    hsvg_base_t  s2_data_reg;
    hsvg_base_t  s2_data_next;
    logic [10:0] dn_red;
    logic [10:0] dn_green;
    logic [10:0] dn_blue;
    logic [10:0] up_green;
    logic [10:0] up_red;

    // Pass the ready back one stage at a time
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Round the hue onto 0..1530 and clamp the top
    always_comb
    begin
        scaled   = 27'(hue) * HUE_SCALE + HUE_ROUND;
        hue_next = scaled[26:16];
        if (hue_next > HUE_MAX)
        begin
            hue_next = HUE_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_hue_reg <= hue_next;
            s1_sat_reg <= saturation;
            s1_val_reg <= value;
        end
    end

    // Pick the ramp segment
    always_comb
    begin
        dn_red   = SEG_2 - s1_hue_reg;
        up_green = s1_hue_reg - SEG_2;
        dn_green = SEG_4 - s1_hue_reg;
        up_red   = s1_hue_reg - SEG_4;
        dn_blue  = HUE_WRAP - s1_hue_reg;

        s2_data_next.sat = s1_sat_reg;
        s2_data_next.val = s1_val_reg;
        if (s1_hue_reg < SEG_2)
        begin
            s2_data_next.blue = 8'd0;
            if (s1_hue_reg < SEG_1)
            begin
                s2_data_next.red   = 8'd255;
                s2_data_next.green = s1_hue_reg[7:0];
            end
            else
            begin
                s2_data_next.red   = dn_red[7:0];
                s2_data_next.green = 8'd255;
            end
        end
        else if (s1_hue_reg < SEG_4)
        begin
            s2_data_next.red = 8'd0;
            if (s1_hue_reg < SEG_3)
            begin
                s2_data_next.green = 8'd255;
                s2_data_next.blue  = up_green[7:0];
            end
            else
            begin
                s2_data_next.green = dn_green[7:0];
                s2_data_next.blue  = 8'd255;
            end
        end
        else
        begin
            s2_data_next.green = 8'd0;
            if (s1_hue_reg < SEG_5)
            begin
                s2_data_next.red  = up_red[7:0];
                s2_data_next.blue = 8'd255;
            end
            else
            begin
                s2_data_next.red  = 8'd255;
                s2_data_next.blue = dn_blue[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/hsvg_mix.sv
`default_nettype none

// Two stages: mix with saturation, then scale by value.
module hsvg_mix (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hsvg_pkg::hsvg_base_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hsvg_pkg::hsvg_rgb_t     out_data
);
    import hsvg_pkg::*;

    logic        s1_valid_reg;
    logic        s1_ready;
    logic [8:0]  s1_red_reg;
    logic [8:0]  s1_green_reg;
    logic [8:0]  s1_blue_reg;
    logic [8:0]  s1_v1_reg;
    logic [8:0]  sat_one;
    logic [7:0]  sat_inv;

    logic        s2_valid_reg;
    logic        s2_ready;
    hsvg_rgb_t   s2_data_reg;
    hsvg_rgb_t   s2_data_next;
    logic [17:0] prod_red;
    logic [17:0] prod_green;
    logic [17:0] prod_blue;

    function automatic logic [8:0] sat_mix(input logic [7:0] c, input logic [8:0] s1,
                                           input logic [7:0] s2);
        logic [16:0] p;
        p = 17'(c) * 17'(s1);
        return p[16:8] + 9'(s2);
    endfunction

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign sat_one = 9'(in_data.sat) + 9'd1;
    assign sat_inv = 8'd255 - in_data.sat;

    // Mix each channel toward white
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_red_reg   <= sat_mix(in_data.red, sat_one, sat_inv);
            s1_green_reg <= sat_mix(in_data.green, sat_one, sat_inv);
            s1_blue_reg  <= sat_mix(in_data.blue, sat_one, sat_inv);
            s1_v1_reg    <= 9'(in_data.val) + 9'd1;
        end
    end

    // Scale by value and keep bits 15..8
    always_comb
    begin
        prod_red   = 18'(s1_red_reg) * 18'(s1_v1_reg);
        prod_green = 18'(s1_green_reg) * 18'(s1_v1_reg);
        prod_blue  = 18'(s1_blue_reg) * 18'(s1_v1_reg);
        s2_data_next.red   = prod_red[15:8];
        s2_data_next.green = prod_green[15:8];
        s2_data_next.blue  = prod_blue[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/hsvg_gamma.sv
`default_nettype none

// Output stage: optional gamma lookup into the output register.
module hsvg_gamma (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               gamma_en,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hsvg_pkg::hsvg_rgb_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hsvg_pkg::hsvg_rgb_t     out_data
);
    import hsvg_pkg::*;

    logic      valid_reg;
    hsvg_rgb_t data_reg;
    hsvg_rgb_t data_next;

    assign in_ready = !valid_reg || out_ready;

    // Map each channel through the curve when enabled
    always_comb
    begin
        if (gamma_en)
        begin
            data_next.red   = GAMMA_ROM[in_data.red];
            data_next.green = GAMMA_ROM[in_data.green];
            data_next.blue  = GAMMA_ROM[in_data.blue];
        end
        else
        begin
            data_next = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/core/hsv_to_rgb_gamma_unit.sv
`default_nettype none
// HSV to RGB conversion with optional gamma 2.6 correction.
// Pipeline: each input beat passes through hue scale, ramp select,
// saturation mix, value scale and gamma lookup, one register stage each.
// Throughput: one beat per cycle; each stage stalls only when the one after it is full.
// Reset: rst_n clears all stage valid bits and gamma_enable; the data path is not reset.
module hsv_to_rgb_gamma_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [15:0]                   hue,
    input  wire logic [7:0]                    saturation,
    input  wire logic [7:0]                    value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hsvg_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import hsvg_pkg::*;

    logic       gamma_enable_reg;
    logic       reg_sel;
    logic       hue_valid;
    logic       hue_ready;
    hsvg_base_t hue_data;
    logic       mix_valid;
    logic       mix_ready;
    hsvg_rgb_t  mix_data;
    hsvg_rgb_t  pix_data;

    // Register port
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1] == REG_GAMMA_ENABLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_enable_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            gamma_enable_reg <= pwdata[0];
        end
    end

    assign prdata = reg_sel ? {31'd0, gamma_enable_reg} : 32'd0;

    // Pipeline
    hsvg_hue u_hue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .value      (value),
        .out_valid  (hue_valid),
        .out_ready  (hue_ready),
        .out_data   (hue_data)
    );

    hsvg_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hue_valid),
        .in_ready  (hue_ready),
        .in_data   (hue_data),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_data  (mix_data)
    );

    hsvg_gamma u_gamma (
        .clk       (clk),
        .rst_n     (rst_n),
        .gamma_en  (gamma_enable_reg),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_data   (mix_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (pix_data)
    );

    assign red   = pix_data.red;
    assign green = pix_data.green;
    assign blue  = pix_data.blue;

endmodule

`default_nettype wire

// File: rtl/core/hsvg_checker.sv
`default_nettype none

module hsvg_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue
);
    localparam logic [2:0] DEPTH = 3'd5;

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Track beats held in the pipeline
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 3'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({red, green, blue}))
        else $error("stalled output beat changed");

    a_no_bubble_block: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input blocked while output stage can advance");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("output beat with nothing in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= DEPTH)
        else $error("more beats in flight than pipeline stages");

endmodule

bind hsv_to_rgb_gamma_unit hsvg_checker u_hsvg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
);

`default_nettype wire

// File: tb/hsv_to_rgb_gamma_unit_tb.sv
`default_nettype none

package hsv_to_rgb_gamma_unit_tb_pkg;

    import hsvg_pkg::*;

    // Gamma 2.6 curve, held apart from the design's copy
    localparam logic [7:0] GAMMA_CURVE [256] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd3,   8'd3,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,
        8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,
        8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,
        8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,
        8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,
        8'd16,  8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,
        8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,
        8'd25,  8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,
        8'd30,  8'd31,  8'd31,  8'd32,  8'd33,  8'd34,  8'd34,  8'd35,
        8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,
        8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,
        8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,
        8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,
        8'd66,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,  8'd73,  8'd75,
        8'd76,  8'd77,  8'd78,  8'd80,  8'd81,  8'd82,  8'd84,  8'd85,
        8'd86,  8'd88,  8'd89,  8'd90,  8'd92,  8'd93,  8'd94,  8'd96,
        8'd97,  8'd99,  8'd100, 8'd102, 8'd103, 8'd105, 8'd106, 8'd108,
        8'd109, 8'd111, 8'd112, 8'd114, 8'd115, 8'd117, 8'd119, 8'd120,
        8'd122, 8'd124, 8'd125, 8'd127, 8'd129, 8'd130, 8'd132, 8'd134,
        8'd136, 8'd137, 8'd139, 8'd141, 8'd143, 8'd145, 8'd146, 8'd148,
        8'd150, 8'd152, 8'd154, 8'd156, 8'd158, 8'd160, 8'd162, 8'd164,
        8'd166, 8'd168, 8'd170, 8'd172, 8'd174, 8'd176, 8'd178, 8'd180,
        8'd182, 8'd184, 8'd186, 8'd188, 8'd191, 8'd193, 8'd195, 8'd197,
        8'd199, 8'd202, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd215,
        8'd218, 8'd220, 8'd223, 8'd225, 8'd227, 8'd230, 8'd232, 8'd235,
        8'd237, 8'd240, 8'd242, 8'd245, 8'd247, 8'd250, 8'd252, 8'd255
    };

    class pixel_scoreboard;
        hsvg_rgb_t   expected_rgb[$];
        logic        gamma_on;
        int unsigned mismatches;

        function new();
            gamma_on   = 1'b0;
            mismatches = 0;
        endfunction

        // Mirror a register write; writes outside the map are dropped
        function void write_reg(int unsigned index, logic [31:0] data);
            if (index == REG_GAMMA_ENABLE)
                gamma_on = data[0];
        endfunction

        // Mix with saturation, scale by value, keep bits 15..8
        function logic [7:0] shade(int unsigned level, logic [7:0] sat, logic [7:0] val);
            int unsigned sat_gain;
            int unsigned grey;
            int unsigned val_gain;
            int unsigned product;
            sat_gain = sat;
            sat_gain = sat_gain + 1;
            grey     = 255 - int'(sat);
            val_gain = val;
            val_gain = val_gain + 1;
            product  = (((level * sat_gain) >> 8) + grey) * val_gain;
            return product[15:8];
        endfunction

        function void note_pixel(logic [15:0] hue, logic [7:0] sat, logic [7:0] val);
            int unsigned angle;
            int unsigned pos;
            int unsigned r;
            int unsigned g;
            int unsigned b;
            hsvg_rgb_t   rgb;
            angle = hue;
            pos   = (angle * 1530 + 32768) >> 16;
            // Top hues round past the circle; clamp into the magenta ramp
            if (pos > 1529)
                pos = 1529;
            if (pos < 510)
            begin
                b = 0;
                r = (pos < 255) ? 255 : 510 - pos;
                g = (pos < 255) ? pos : 255;
            end
            else if (pos < 1020)
            begin
                r = 0;
                g = (pos < 765) ? 255 : 1020 - pos;
                b = (pos < 765) ? pos - 510 : 255;
            end
            else
            begin
                g = 0;
                r = (pos < 1275) ? pos - 1020 : 255;
                b = (pos < 1275) ? 255 : 1530 - pos;
            end
            rgb.red   = shade(r, sat, val);
            rgb.green = shade(g, sat, val);
            rgb.blue  = shade(b, sat, val);
            if (gamma_on)
            begin
                rgb.red   = GAMMA_CURVE[rgb.red];
                rgb.green = GAMMA_CURVE[rgb.green];
                rgb.blue  = GAMMA_CURVE[rgb.blue];
            end
            expected_rgb.push_back(rgb);
        endfunction

        function void check_pixel(hsvg_rgb_t got);
            hsvg_rgb_t want;
            if (expected_rgb.size() == 0)
            begin
                $error("unexpected pixel red=%0d green=%0d blue=%0d",
                       got.red, got.green, got.blue);
                mismatches++;
                return;
            end
            want = expected_rgb.pop_front();
            if (got.red !== want.red)
            begin
                $error("red: expected %0d, got %0d", want.red, got.red);
                mismatches++;
            end
            if (got.green !== want.green)
            begin
                $error("green: expected %0d, got %0d", want.green, got.green);
                mismatches++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue: expected %0d, got %0d", want.blue, got.blue);
                mismatches++;
            end
        endfunction
    endclass

endpackage

module hsv_to_rgb_gamma_unit_tb;

    import hsvg_pkg::*;
    import hsv_to_rgb_gamma_unit_tb_pkg::*;

    localparam int unsigned PIPE_DEPTH      = 5;
    localparam int unsigned SETTLE_CYCLES   = 2 * PIPE_DEPTH + 4;
    localparam int unsigned STALL_LIMIT     = 1000;
    localparam int unsigned HOLD_CYCLES     = 60;
    localparam int unsigned PHASES          = 5;
    localparam int unsigned ITEMS_PER_PHASE = 130;
    localparam int unsigned REG_COUNT       = 1;

    localparam logic [APB_AW-1:0] GAMMA_ADDR = APB_AW'(4 * REG_GAMMA_ENABLE);
    localparam logic [APB_AW-1:0] SPARE_ADDR = APB_AW'(4 * REG_COUNT);

    // Register writes ahead of each random phase: on, off through masked bits,
    // on, a write outside the map that must not alias, then off
    localparam logic [APB_AW-1:0] PHASE_ADDR [PHASES] =
        '{GAMMA_ADDR, GAMMA_ADDR, GAMMA_ADDR, SPARE_ADDR, GAMMA_ADDR};
    localparam logic [31:0] PHASE_DATA [PHASES] =
        '{32'h0000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000};

    // Hue positions at the ramp boundaries
    localparam int unsigned EDGE_POS [12] =
        '{0, 254, 255, 509, 510, 764, 765, 1019, 1020, 1274, 1275, 1529};

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [15:0] hue        = '0;
    logic [7:0]  saturation = '0;
    logic [7:0]  value      = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    pixel_scoreboard pixels = new();

    int unsigned cfg_errors  = 0;
    int unsigned idle_cycles = 0;
    logic        watch_on    = 1'b0;
    logic        hold_req    = 1'b0;
    int unsigned hold_left   = 0;
    logic [15:0] ready_mask  = 16'hFFFF;
    logic [3:0]  ready_step  = '0;

    hsv_to_rgb_gamma_unit uut (.*);

    always #5 clk = ~clk;

    // Check each output beat against the oldest expected pixel
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            pixels.check_pixel(hsvg_rgb_t'{red, green, blue});
    end

    // Drop the run if neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if (watch_on)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: a fresh 16-bit ready pattern each round, plus long hold-offs
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (ready_step == 0)
        begin
            case ($urandom_range(0, 5))
                0:       ready_mask = 16'hFFFF;
                1:       ready_mask = 16'hFFFF;
                2:       ready_mask = 16'($urandom);
                3:       ready_mask = 16'($urandom) | 16'($urandom);
                4:       ready_mask = 16'h00FF;
                default: ready_mask = 16'($urandom) & 16'($urandom);
            endcase
        end
        if (hold_left != 0)
        begin
            out_ready = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready = ready_mask[ready_step];
        ready_step = ready_step + 1;
    end

    // Offer one pixel and hold it until the block takes it
    task automatic send_pixel(input logic [15:0] h, input logic [7:0] s, input logic [7:0] v);
        @(negedge clk);
        in_valid   = 1'b1;
        hue        = h;
        saturation = s;
        value      = v;
        do
            @(posedge clk);
        while (!in_ready);
        pixels.note_pixel(h, s, v);
    endtask

    // Idle the sender with junk on the payload
    task automatic pause_sender(input int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid   = 1'b0;
            hue        = 16'($urandom);
            saturation = 8'($urandom);
            value      = 8'($urandom);
        end
    endtask

    // Let every expected pixel come back, then let the pipe settle
    task automatic drain_pixels();
        pause_sender(1);
        while (pixels.expected_rgb.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pixels.write_reg(addr >> 2, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Read the gamma register back and compare with the mirrored copy
    task automatic apb_check_gamma();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = GAMMA_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {31'b0, pixels.gamma_on})
        begin
            $error("gamma_enable: expected %0d, got %0d", pixels.gamma_on, prdata);
            cfg_errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned sent;
        int unsigned burst;
        int unsigned n;
        int unsigned seg;
        logic [15:0] h;
        logic [7:0]  s;
        logic [7:0]  v;

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n    = 1'b1;
        watch_on = 1'b1;
        apb_check_gamma();

        // Directed: ramp boundaries, hue rounding past the top, white and black
        for (n = 0; n < 12; n++)
            send_pixel(16'((EDGE_POS[n] * 65536) / 1530), 8'd255, 8'd255);
        send_pixel(16'd65514, 8'd255, 8'd255);
        send_pixel(16'd65515, 8'd255, 8'd255);
        send_pixel(16'hFFFF, 8'd255, 8'd255);
        send_pixel(16'h0000, 8'd0, 8'd255);
        send_pixel(16'h0000, 8'd0, 8'd0);
        send_pixel(16'd21845, 8'd128, 8'd0);
        send_pixel(16'd43690, 8'd255, 8'd1);
        send_pixel(16'd10923, 8'd1, 8'd255);
        send_pixel(16'hFFFF, 8'd0, 8'd0);
        drain_pixels();

        // Random phases, one register setting each
        for (phase = 0; phase < PHASES; phase++)
        begin
            apb_write(PHASE_ADDR[phase], PHASE_DATA[phase]);
            apb_check_gamma();
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 24);
                for (n = 0; n < burst && sent < ITEMS_PER_PHASE; n++)
                begin
                    case ($urandom_range(0, 7))
                        0:       h = 16'($urandom_range(65500, 65535));
                        1:
                        begin
                            seg = $urandom_range(1, 5);
                            h = 16'((seg * 255 * 65536) / 1530 + $urandom_range(0, 40) - 20);
                        end
                        2:       h = 16'($urandom_range(0, 40));
                        default: h = 16'($urandom);
                    endcase
                    case ($urandom_range(0, 5))
                        0:       s = 8'd0;
                        1:       s = 8'd255;
                        default: s = 8'($urandom);
                    endcase
                    case ($urandom_range(0, 5))
                        0:       v = 8'd0;
                        1:       v = 8'd255;
                        default: v = 8'($urandom);
                    endcase
                    send_pixel(h, s, v);
                    sent++;
                    // Hold off the receiver while the sender keeps pushing
                    if ((phase == 1 || phase == 3) && sent == 30)
                        hold_req = 1'b1;
                end
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 8));
            end
            drain_pixels();
        end

        if (pixels.mismatches == 0 && cfg_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
